[design/wdh_pkg.sv]
// ----------------------------------------------------------------------------
// wdh_pkg
// Shared types and constants for the wear detection block: register map,
// threshold register bundle and reset values.
// ----------------------------------------------------------------------------
package wdh_pkg;

  localparam int LIMIT_W   = 19;
  localparam int POINTS_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic                START_WORN_RST    = 1'b1;
  localparam logic [LIMIT_W-1:0]  IR_LIMIT_RST      = 19'd360000;
  localparam logic [LIMIT_W-1:0]  RED_LIMIT_RST     = 19'd360000;
  localparam logic [POINTS_W-1:0] UNWEAR_POINTS_RST = 16'd10;
  localparam logic [POINTS_W-1:0] WEAR_POINTS_RST   = 16'd50;
  localparam logic [POINTS_W-1:0] IR_ONLY_PTS_RST   = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_WORN    = 3'd0,
    CFG_IR_LIMIT      = 3'd1,
    CFG_RED_LIMIT     = 3'd2,
    CFG_UNWEAR_POINTS = 3'd3,
    CFG_WEAR_POINTS   = 3'd4,
    CFG_IR_ONLY_PTS   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]  ir_limit;
    logic [LIMIT_W-1:0]  red_limit;
    logic [POINTS_W-1:0] unwear_points;
    logic [POINTS_W-1:0] wear_points;
    logic [POINTS_W-1:0] ir_only_points;
  } thresh_t;

  // reload of the worn flag from a start_worn write
  typedef struct packed {
    logic load;
    logic value;
  } reinit_t;

endpackage

[design/wdh_core.sv]
// ----------------------------------------------------------------------------
// wdh_core
// Worn flag and the four event counters with their hysteresis decision.
// One sample pair is evaluated per step; worn_nxt is the flag after it.
// ----------------------------------------------------------------------------
module wdh_core import wdh_pkg::*; #(
  parameter int COUNT_WIDTH  = 16,
  parameter int SAMPLE_WIDTH = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic signed [SAMPLE_WIDTH-1:0] ir_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] red_sample,
  input  thresh_t                        thr,
  input  reinit_t                        reinit,
  output logic                           worn_nxt
);

  localparam int CMP_W = ((SAMPLE_WIDTH > LIMIT_W) ? SAMPLE_WIDTH : LIMIT_W) + 1;

  logic                   worn_r;
  logic [COUNT_WIDTH-1:0] ir_off_r,  ir_off_nxt;
  logic [COUNT_WIDTH-1:0] red_off_r, red_off_nxt;
  logic [COUNT_WIDTH-1:0] ir_on_r,   ir_on_nxt;
  logic [COUNT_WIDTH-1:0] red_on_r,  red_on_nxt;

  logic signed [CMP_W-1:0] ir_ext, red_ext, ir_lim_ext, red_lim_ext;
  logic                    ir_low, red_low, red_present, flip;

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    bump = (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
  endfunction

  always_comb begin
    ir_ext      = CMP_W'(ir_sample);
    red_ext     = CMP_W'(red_sample);
    ir_lim_ext  = $signed(CMP_W'(thr.ir_limit));
    red_lim_ext = $signed(CMP_W'(thr.red_limit));
    ir_low      = ir_ext <= ir_lim_ext;
    red_low     = red_ext <= red_lim_ext;
    red_present = !red_sample[SAMPLE_WIDTH-1];
  end

  always_comb begin
    ir_off_nxt  = ir_off_r;
    red_off_nxt = red_off_r;
    ir_on_nxt   = ir_on_r;
    red_on_nxt  = red_on_r;
    flip        = 1'b0;
    if (worn_r) begin
      if (ir_low) ir_off_nxt = bump(ir_off_r);
      if (red_present && red_low) red_off_nxt = bump(red_off_r);
      flip = (POINTS_W'(ir_off_nxt) > thr.unwear_points) ||
             (POINTS_W'(red_off_nxt) > thr.unwear_points);
    end else begin
      if (!ir_low) ir_on_nxt = bump(ir_on_r);
      if (red_present) begin
        if (!red_low) red_on_nxt = bump(red_on_r);
        flip = (POINTS_W'(ir_on_nxt) > thr.wear_points) &&
               (POINTS_W'(red_on_nxt) > thr.wear_points);
      end else begin
        flip = POINTS_W'(ir_on_nxt) > thr.ir_only_points;
      end
    end
    worn_nxt = worn_r ^ flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worn_r    <= START_WORN_RST;
      ir_off_r  <= '0;
      red_off_r <= '0;
      ir_on_r   <= '0;
      red_on_r  <= '0;
    end else if (reinit.load) begin
      worn_r    <= reinit.value;
      ir_off_r  <= '0;
      red_off_r <= '0;
      ir_on_r   <= '0;
      red_on_r  <= '0;
    end else if (step) begin
      worn_r <= worn_nxt;
      if (flip) begin
        ir_off_r  <= '0;
        red_off_r <= '0;
        ir_on_r   <= '0;
        red_on_r  <= '0;
      end else begin
        ir_off_r  <= ir_off_nxt;
        red_off_r <= red_off_nxt;
        ir_on_r   <= ir_on_nxt;
        red_on_r  <= red_on_nxt;
      end
    end
  end

  // on counters only run while unworn, off counters only while worn
  a_on_idle_when_worn: assert property (@(posedge clk) disable iff (!rst_n)
    worn_r |-> (ir_on_r == '0 && red_on_r == '0))
    else $error("wear counters nonzero while worn");

  a_off_idle_when_unworn: assert property (@(posedge clk) disable iff (!rst_n)
    !worn_r |-> (ir_off_r == '0 && red_off_r == '0))
    else $error("removal counters nonzero while unworn");

  a_flip_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !reinit.load && flip) |=>
      (ir_off_r == '0 && red_off_r == '0 && ir_on_r == '0 && red_on_r == '0))
    else $error("counters not cleared on flag change");

endmodule

[design/wear_detect_hysteresis_unit.sv]
// ----------------------------------------------------------------------------
// wear_detect_hysteresis_unit
// Wear detection with hysteresis counters on infrared and red DC samples.
// ----------------------------------------------------------------------------
// One sample pair is taken every clock cycle unless out_tready holds the
// result side, and each gives one worn flag. A request passes an input
// register and then the result register before its flag is presented on
// the result side; the only feedback is the worn flag and counter update,
// held in the registers of wdh_core. Configuration writes go through
// cfg_valid/cfg_ready (always ready) and are registered in thr_r; a
// start_worn write also reloads the flag and clears the counters.
module wear_detect_hysteresis_unit import wdh_pkg::*; #(
  parameter int COUNT_WIDTH  = 16,
  parameter int SAMPLE_WIDTH = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [SAMPLE_WIDTH-1:0] ir_sample, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] red_sample
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [0] worn
  output logic [7:0]                out_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  logic                           in_vld_r;
  logic signed [SAMPLE_WIDTH-1:0] ir_r, red_r;
  logic                           out_vld_r, out_worn_r;
  logic                           advance, step, worn_nxt;
  thresh_t                        thr_r;
  reinit_t                        reinit;
  logic                           cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign advance   = !out_vld_r || out_tready;
  assign step      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  always_comb begin
    reinit.load  = cfg_fire && (cfg_index == CFG_START_WORN);
    reinit.value = cfg_data[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.ir_limit       <= IR_LIMIT_RST;
      thr_r.red_limit      <= RED_LIMIT_RST;
      thr_r.unwear_points  <= UNWEAR_POINTS_RST;
      thr_r.wear_points    <= WEAR_POINTS_RST;
      thr_r.ir_only_points <= IR_ONLY_PTS_RST;
    end else if (cfg_fire) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_WORN:    ;
        CFG_IR_LIMIT:      thr_r.ir_limit       <= cfg_data;
        CFG_RED_LIMIT:     thr_r.red_limit      <= cfg_data;
        CFG_UNWEAR_POINTS: thr_r.unwear_points  <= cfg_data[POINTS_W-1:0];
        CFG_WEAR_POINTS:   thr_r.wear_points    <= cfg_data[POINTS_W-1:0];
        CFG_IR_ONLY_PTS:   thr_r.ir_only_points <= cfg_data[POINTS_W-1:0];
        default:           ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ir_r  <= in_tdata[SAMPLE_WIDTH-1:0];
      red_r <= in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    end
  end

  wdh_core #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .ir_sample  (ir_r),
    .red_sample (red_r),
    .thr        (thr_r),
    .reinit     (reinit),
    .worn_nxt   (worn_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_worn_r <= worn_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0, out_worn_r};

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_vld_r && out_vld_r && !out_tready))
    else $error("input stalled without output backpressure");

  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r)
    else $error("evaluated request produced no result");

  a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_vld_r && !in_vld_r) |=> !out_vld_r)
    else $error("result appeared without a request");

endmodule
